### hdl/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by the decoder top level, its port checker and the testbench; depends on nothing.
`default_nettype none

package u8sd_pkg;

   // result kinds
   typedef enum logic [1:0] {
      KIND_DECODED  = 2'd0,
      KIND_REPLACED = 2'd1,
      KIND_ILLEGAL  = 2'd2,
      KIND_CUT      = 2'd3
   } kind_type;

   // register word index (paddr[2])
   localparam logic REG_STRICT  = 1'b0;
   localparam logic REG_PARTIAL = 1'b1;

   // csr address width and reset values
   localparam int unsigned CSR_ADDR_W    = 3;
   localparam logic        STRICT_RESET  = 1'b1;
   localparam logic        PARTIAL_RESET = 1'b0;

   // code point constants
   localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [20:0] CP_MAX         = 21'h10FFFF;
   localparam logic [20:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [20:0] CP_SURR_HI     = 21'h00DFFF;

   // byte class limits
   localparam logic [7:0] BYTE_ASCII_END = 8'h80;
   localparam logic [7:0] LEAD2_LO       = 8'hC2;
   localparam logic [7:0] LEAD2_HI       = 8'hDF;
   localparam logic [7:0] LEAD3_LO       = 8'hE0;
   localparam logic [7:0] LEAD3_HI       = 8'hEF;
   localparam logic [7:0] LEAD4_LO       = 8'hF0;
   localparam logic [7:0] LEAD4_HI       = 8'hF4;
   localparam logic [7:0] LEAD_E0        = 8'hE0;
   localparam logic [7:0] LEAD_ED        = 8'hED;
   localparam logic [7:0] LEAD_F0        = 8'hF0;
   localparam logic [7:0] LEAD_F4        = 8'hF4;
   localparam logic [7:0] CONT_LO        = 8'h80;
   localparam logic [7:0] CONT_HI        = 8'hBF;
   localparam logic [7:0] CONT_LO_E0     = 8'hA0;
   localparam logic [7:0] CONT_HI_ED     = 8'h9F;
   localparam logic [7:0] CONT_LO_F0     = 8'h90;
   localparam logic [7:0] CONT_HI_F4     = 8'h8F;

   // one result item
   typedef struct packed {
      logic [20:0] code_point;
      kind_type    kind;
      logic        last_of_run;
      logic        stream_done;
   } res_type;

   // outcome of taking a byte as a lead
   typedef struct packed {
      logic        emit;
      res_type     res;
      logic        load;
      logic [2:0]  need;
      logic [20:0] acc;
      logic        stop;
   } lead_type;

   // result queue depth
   localparam int unsigned FIFO_DEPTH = 4;
   localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

endpackage

`default_nettype wire

### hdl/utf8_stream_decoder_unit.sv
// UTF-8 byte stream to code point decoder, top level.
// Depends on u8sd_pkg for result types, kinds and byte limits.
//
// Usage: bytes enter on the req_ channel (req_input_byte, req_last_byte marks
// the final byte of a stream); decoded code points, replacements and stop
// results leave on the rsp_ channel. A transfer happens on a channel at a
// clock edge where its valid is high and its stall is low.
// Each byte is decoded in the cycle it is taken; its zero, one or two results
// go into a four-entry result queue and the first is offered on the next
// cycle. One byte per cycle is taken while at most two results are queued,
// so bytes giving one result stream at one per cycle; a byte giving two
// results needs two transfers on the single result port.
// When the receiver stalls, the queue fills and req_stall rises once more
// than two results wait.
// The APB-style port writes strict_mode (address 0) and partial_input
// (address 4); write it only while no transfer is in flight.
// Synchronous reset empties the queue, drops any pending sequence and the
// halted condition, and restores strict_mode = 1, partial_input = 0.
`default_nettype none

module utf8_stream_decoder_unit
   import u8sd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // input byte channel
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [7:0]            req_input_byte,
   input  wire logic                  req_last_byte,
   // result channel
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [20:0]                rsp_code_point,
   output logic [1:0]                 rsp_kind,
   output logic                       rsp_last_of_run,
   output logic                       rsp_stream_done,
   // configuration port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic [31:0]                prdata,
   output logic                       pready
);

   // configuration registers
   logic strict_ff, partial_ff;
   logic csr_wr;

   // decoder state
   logic [7:0]  lead_ff, lead_in;
   logic [2:0]  need_ff, need_in;
   logic [1:0]  seen_ff, seen_in;
   logic [20:0] acc_ff, acc_in;
   logic        halted_ff, halted_in;

   // result queue
   res_type            fifo_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff, count_in;

   // per-byte decode results
   res_type     res_c [2];
   logic [1:0]  cnt;
   logic        stopped;
   logic [7:0]  lo, hi;
   logic [1:0]  seen_next;
   lead_type    ld;
   logic        req_take, rsp_take;

   // classify a byte taken as a lead
   function automatic lead_type take_lead(input logic [7:0] b, input logic strict);
      lead_type l;
      l = '0;
      priority if (b < BYTE_ASCII_END) begin
         l.emit            = 1'b1;
         l.res.code_point  = {13'd0, b};
         l.res.kind        = KIND_DECODED;
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         l.load = 1'b1;
         l.need = 3'd1;
         l.acc  = {16'd0, b[4:0]};
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         l.load = 1'b1;
         l.need = 3'd2;
         l.acc  = {17'd0, b[3:0]};
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         l.load = 1'b1;
         l.need = 3'd3;
         l.acc  = {18'd0, b[2:0]};
      end else if (strict) begin
         l.emit           = 1'b1;
         l.res.code_point = '0;
         l.res.kind       = KIND_ILLEGAL;
         l.stop           = 1'b1;
      end else begin
         l.emit           = 1'b1;
         l.res.code_point = CP_REPLACEMENT;
         l.res.kind       = KIND_REPLACED;
      end
      return l;
   endfunction

   // csr write and read
   assign pready = 1'b1;
   assign csr_wr = psel & penable & pwrite & pready;

   always_comb begin
      prdata = '0;
      unique case (paddr[2])
         REG_STRICT:  prdata[0] = strict_ff;
         REG_PARTIAL: prdata[0] = partial_ff;
         default:     prdata    = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strict_ff  <= STRICT_RESET;
         partial_ff <= PARTIAL_RESET;
      end else if (csr_wr) begin
         unique case (paddr[2])
            REG_STRICT:  strict_ff  <= pwdata[0];
            REG_PARTIAL: partial_ff <= pwdata[0];
            default:     strict_ff  <= strict_ff;
         endcase
      end
   end

   // handshakes
   assign req_stall = (count_ff > (FIFO_AW+1)'(FIFO_DEPTH - 2));
   assign req_take  = req_valid & ~req_stall;
   assign rsp_valid = (count_ff != '0);
   assign rsp_take  = rsp_valid & ~rsp_stall;

   // byte decode: next state and up to two results
   always_comb begin
      res_c[0]  = '0;
      res_c[1]  = '0;
      cnt       = '0;
      stopped   = 1'b0;
      lead_in   = lead_ff;
      need_in   = need_ff;
      seen_in   = seen_ff;
      acc_in    = acc_ff;
      halted_in = halted_ff;
      lo        = CONT_LO;
      hi        = CONT_HI;
      seen_next = '0;
      ld        = '0;

      if (halted_ff) begin
         // drop bytes up to the end mark
         if (req_last_byte) begin
            halted_in = 1'b0;
         end
      end else begin
         if (need_ff != '0) begin
            // continuation range, narrowed on the first one
            if (seen_ff == '0) begin
               priority if (lead_ff == LEAD_E0) begin
                  lo = CONT_LO_E0;
               end else if (lead_ff == LEAD_ED) begin
                  hi = CONT_HI_ED;
               end else if (lead_ff == LEAD_F0) begin
                  lo = CONT_LO_F0;
               end else if (lead_ff == LEAD_F4) begin
                  hi = CONT_HI_F4;
               end else begin
                  lo = CONT_LO;
               end
            end
            if (req_input_byte >= lo && req_input_byte <= hi) begin
               seen_next = seen_ff + 2'd1;
               acc_in    = {acc_ff[14:0], req_input_byte[5:0]};
               seen_in   = seen_next;
               if ({1'b0, seen_next} >= need_ff) begin
                  res_c[0].code_point = {acc_ff[14:0], req_input_byte[5:0]};
                  res_c[0].kind       = KIND_DECODED;
                  cnt                 = 2'd1;
                  lead_in             = '0;
                  need_in             = '0;
                  seen_in             = '0;
                  acc_in              = '0;
               end
            end else begin
               // breaking byte
               lead_in = '0;
               need_in = '0;
               seen_in = '0;
               acc_in  = '0;
               if (strict_ff) begin
                  res_c[0].kind = KIND_ILLEGAL;
                  cnt           = 2'd1;
                  stopped       = 1'b1;
               end else begin
                  res_c[0].code_point = CP_REPLACEMENT;
                  res_c[0].kind       = KIND_REPLACED;
                  cnt                 = 2'd1;
                  ld                  = take_lead(req_input_byte, strict_ff);
               end
            end
         end else begin
            ld = take_lead(req_input_byte, strict_ff);
         end

         // apply the lead outcome
         if (ld.emit) begin
            res_c[cnt[0]] = ld.res;
            cnt           = cnt + 2'd1;
         end
         if (ld.load) begin
            lead_in = req_input_byte;
            need_in = ld.need;
            seen_in = '0;
            acc_in  = ld.acc;
         end
         if (ld.stop) begin
            stopped = 1'b1;
         end

         // stream end
         if (req_last_byte) begin
            if (need_in != '0 && !stopped) begin
               if (strict_ff || partial_ff) begin
                  res_c[cnt[0]].code_point = '0;
                  res_c[cnt[0]].kind       = KIND_CUT;
               end else begin
                  res_c[cnt[0]].code_point = CP_REPLACEMENT;
                  res_c[cnt[0]].kind       = KIND_REPLACED;
               end
               cnt = cnt + 2'd1;
            end
            lead_in   = '0;
            need_in   = '0;
            seen_in   = '0;
            acc_in    = '0;
            halted_in = 1'b0;
         end else if (stopped) begin
            halted_in = 1'b1;
         end

         // flags on the final result of this byte
         if (cnt != '0) begin
            res_c[cnt[1]].last_of_run = 1'b1;
            res_c[cnt[1]].stream_done = req_last_byte | stopped;
         end
      end
   end

   // queue occupancy
   always_comb begin
      count_in = count_ff;
      if (req_take) begin
         count_in = count_in + {1'b0, cnt};
      end
      if (rsp_take) begin
         count_in = count_in - (FIFO_AW+1)'(1);
      end
   end

   // decoder state and queue control
   always_ff @(posedge clock) begin
      if (reset) begin
         lead_ff   <= '0;
         need_ff   <= '0;
         seen_ff   <= '0;
         acc_ff    <= '0;
         halted_ff <= 1'b0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_take) begin
            lead_ff   <= lead_in;
            need_ff   <= need_in;
            seen_ff   <= seen_in;
            acc_ff    <= acc_in;
            halted_ff <= halted_in;
            wr_ptr_ff <= wr_ptr_ff + FIFO_AW'(cnt);
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_AW'(1);
         end
         count_ff <= count_in;
      end
   end

   // queue payload
   always_ff @(posedge clock) begin
      if (req_take && cnt != '0) begin
         fifo_ff[wr_ptr_ff] <= res_c[0];
      end
      if (req_take && cnt == 2'd2) begin
         fifo_ff[wr_ptr_ff + FIFO_AW'(1)] <= res_c[1];
      end
   end

   // result port
   assign rsp_code_point  = fifo_ff[rd_ptr_ff].code_point;
   assign rsp_kind        = fifo_ff[rd_ptr_ff].kind;
   assign rsp_last_of_run = fifo_ff[rd_ptr_ff].last_of_run;
   assign rsp_stream_done = fifo_ff[rd_ptr_ff].stream_done;

endmodule

`default_nettype wire

### hdl/u8sd_checker.sv
// Port-level checker for the UTF-8 stream decoder, bound to the top level.
// Depends on u8sd_pkg for kinds and code point limits.
`default_nettype none

module u8sd_checker
   import u8sd_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [20:0] rsp_code_point,
   input wire logic [1:0]  rsp_kind,
   input wire logic        rsp_last_of_run,
   input wire logic        rsp_stream_done
);

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_kind) && $stable(rsp_stream_done))
      else $error("result changed while stalled");

   // decoded values are scalar values
   a_scalar: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_DECODED |->
         rsp_code_point <= CP_MAX
         && (rsp_code_point < CP_SURR_LO || rsp_code_point > CP_SURR_HI))
      else $error("decoded value not a scalar value");

   // replacements carry U+FFFD
   a_repl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REPLACED |-> rsp_code_point == CP_REPLACEMENT)
      else $error("replacement without U+FFFD");

   // stop results end the run and the stream with a zero value
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ILLEGAL || rsp_kind == KIND_CUT) |->
         rsp_code_point == '0 && rsp_stream_done && rsp_last_of_run)
      else $error("stop result malformed");

   // end of stream is always the end of a run
   a_done_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stream_done |-> rsp_last_of_run)
      else $error("stream end not on last result of byte");

endmodule

bind utf8_stream_decoder_unit u8sd_checker u_u8sd_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_code_point  (rsp_code_point),
   .rsp_kind        (rsp_kind),
   .rsp_last_of_run (rsp_last_of_run),
   .rsp_stream_done (rsp_stream_done)
);

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for utf8_stream_decoder_unit: directed and random byte streams
// are checked against a predictor of the decode rules, with idle and stall cycles on both sides.
// Depends on u8sd_pkg and the decoder top level only.
`timescale 1ns / 1ps

import u8sd_pkg::*;

// decode predictor plus the queue of code point results still to arrive
class cp_scoreboard;
   logic        strict_on;
   logic        partial_on;
   logic [7:0]  seq_lead;
   logic [2:0]  seq_need;
   logic [1:0]  seq_seen;
   logic [20:0] seq_acc;
   logic        halted;
   res_type     expected_q[$];
   res_type     run_q[$];
   int unsigned fails;

   function new();
      fails      = 0;
      strict_on  = STRICT_RESET;
      partial_on = PARTIAL_RESET;
      halted     = 1'b0;
      clear_seq();
   endfunction

   function void clear_seq();
      seq_lead = 8'd0;
      seq_need = 3'd0;
      seq_seen = 2'd0;
      seq_acc  = 21'd0;
   endfunction

   function void set_reg(logic idx, logic val);
      if (idx == REG_STRICT) begin
         strict_on = val;
      end else begin
         partial_on = val;
      end
   endfunction

   function void add_result(logic [20:0] cp, kind_type k);
      res_type r;
      r.code_point  = cp;
      r.kind        = k;
      r.last_of_run = 1'b0;
      r.stream_done = 1'b0;
      run_q.push_back(r);
   endfunction

   function void load_seq(logic [7:0] b, logic [2:0] need, logic [20:0] acc);
      seq_lead = b;
      seq_need = need;
      seq_seen = 2'd0;
      seq_acc  = acc;
   endfunction

   // byte taken as the start of a sequence; returns 1 on a strict stop
   function bit take_lead(logic [7:0] b);
      if (b < BYTE_ASCII_END) begin
         add_result({13'd0, b}, KIND_DECODED);
      end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         load_seq(b, 3'd1, {16'd0, b[4:0]});
      end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
         load_seq(b, 3'd2, {17'd0, b[3:0]});
      end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
         load_seq(b, 3'd3, {18'd0, b[2:0]});
      end else if (strict_on) begin
         add_result(21'd0, KIND_ILLEGAL);
         return 1'b1;
      end else begin
         add_result(CP_REPLACEMENT, KIND_REPLACED);
      end
      return 1'b0;
   endfunction

   // predicts the results of one accepted byte; returns 0 if dropped while halted
   function bit note_byte(logic [7:0] b, logic last);
      bit         stopped;
      logic [7:0] lo;
      logic [7:0] hi;
      stopped = 1'b0;
      run_q.delete();
      if (halted) begin
         if (last) begin
            halted = 1'b0;
         end
         return 1'b0;
      end
      if (seq_need != 3'd0) begin
         lo = CONT_LO;
         hi = CONT_HI;
         // tighter first continuation range rules out overlongs, surrogates, > U+10FFFF
         if (seq_seen == 2'd0) begin
            if (seq_lead == LEAD_E0) begin
               lo = CONT_LO_E0;
            end else if (seq_lead == LEAD_ED) begin
               hi = CONT_HI_ED;
            end else if (seq_lead == LEAD_F0) begin
               lo = CONT_LO_F0;
            end else if (seq_lead == LEAD_F4) begin
               hi = CONT_HI_F4;
            end
         end
         if (b >= lo && b <= hi) begin
            seq_acc  = {seq_acc[14:0], b[5:0]};
            seq_seen = seq_seen + 2'd1;
            if ({1'b0, seq_seen} >= seq_need) begin
               add_result(seq_acc, KIND_DECODED);
               clear_seq();
            end
         end else begin
            // breaking byte ends the pending subpart
            clear_seq();
            if (strict_on) begin
               add_result(21'd0, KIND_ILLEGAL);
               stopped = 1'b1;
            end else begin
               add_result(CP_REPLACEMENT, KIND_REPLACED);
               stopped = take_lead(b);
            end
         end
      end else begin
         stopped = take_lead(b);
      end
      // stream end with a sequence still open
      if (last) begin
         if (seq_need != 3'd0 && !stopped) begin
            if (strict_on || partial_on) begin
               add_result(21'd0, KIND_CUT);
            end else begin
               add_result(CP_REPLACEMENT, KIND_REPLACED);
            end
         end
         clear_seq();
         halted = 1'b0;
      end else if (stopped) begin
         halted = 1'b1;
      end
      foreach (run_q[i]) begin
         if (i == run_q.size() - 1) begin
            run_q[i].last_of_run = 1'b1;
            run_q[i].stream_done = last || stopped;
         end
         expected_q.push_back(run_q[i]);
      end
      return 1'b1;
   endfunction

   // compares one result transfer with the oldest expected result
   function void check_result(logic [20:0] cp, logic [1:0] kind, logic lor, logic sd);
      res_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected result: code_point %h kind %0d", cp, kind);
         fails++;
         return;
      end
      want = expected_q.pop_front();
      if (cp !== want.code_point) begin
         $error("code_point: expected %h, got %h", want.code_point, cp);
         fails++;
      end
      if (kind !== want.kind) begin
         $error("kind: expected %0d, got %0d", want.kind, kind);
         fails++;
      end
      if (lor !== want.last_of_run) begin
         $error("last_of_run: expected %b, got %b", want.last_of_run, lor);
         fails++;
      end
      if (sd !== want.stream_done) begin
         $error("stream_done: expected %b, got %b", want.stream_done, sd);
         fails++;
      end
   endfunction
endclass

module tb;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned PHASE_BYTES  = 375;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [7:0]            req_input_byte;
   logic                  req_last_byte;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [20:0]           rsp_code_point;
   logic [1:0]            rsp_kind;
   logic                  rsp_last_of_run;
   logic                  rsp_stream_done;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   cp_scoreboard sb = new();
   int unsigned  bytes_decoded = 0;
   int unsigned  req_calm = 0;
   int unsigned  rsp_calm = 0;
   int unsigned  cycle_count = 0;

   utf8_stream_decoder_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_input_byte(req_input_byte), .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_code_point(rsp_code_point), .rsp_kind(rsp_kind),
      .rsp_last_of_run(rsp_last_of_run), .rsp_stream_done(rsp_stream_done),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // idle cycles per transfer, with occasional stretches of none
   function automatic int unsigned draw_gap(inout int unsigned calm);
      if (calm != 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(20, 60);
      end
      return $urandom_range(0, 6);
   endfunction

   // one byte transfer on the request side; every accepted byte counts
   task automatic send_byte(input logic [7:0] b, input logic last);
      int unsigned gap;
      gap = draw_gap(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_input_byte <= b;
      req_last_byte  <= last;
      do @(posedge clock); while (req_stall !== 1'b0);
      void'(sb.note_byte(b, last));
      bytes_decoded++;
   endtask

   // wait until every expected result has come and the decoder is idle
   task automatic quiesce();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write followed by a read back
   task automatic csr_write(input logic idx, input logic val);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {31'd0, val};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      sb.set_reg(idx, val);
      pwrite  <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (pready !== 1'b1);
      if (prdata[0] !== val) begin
         $error("prdata: expected %b, got %b", val, prdata[0]);
         sb.fails++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // stream of random characters, some broken; last byte carries the end mark
   task automatic play_stream(input int unsigned n_chars, input int unsigned break_pct);
      logic [7:0]  bq[$];
      logic [7:0]  seq[4];
      logic [20:0] cp;
      int unsigned cls;
      int unsigned len;
      for (int c = 0; c < n_chars; c++) begin
         cls = $urandom_range(0, 3);
         case (cls)
            0: begin
               cp     = 21'($urandom_range(0, 'h7F));
               seq[0] = cp[7:0];
               len    = 1;
            end
            1: begin
               cp     = 21'($urandom_range('h80, 'h7FF));
               seq[0] = {3'b110, cp[10:6]};
               seq[1] = {2'b10, cp[5:0]};
               len    = 2;
            end
            2: begin
               cp = 21'($urandom_range('h800, 'hFFFF));
               if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) begin
                  cp = cp ^ 21'h001000;
               end
               seq[0] = {4'b1110, cp[15:12]};
               seq[1] = {2'b10, cp[11:6]};
               seq[2] = {2'b10, cp[5:0]};
               len    = 3;
            end
            default: begin
               cp     = 21'($urandom_range('h10000, CP_MAX));
               seq[0] = {5'b11110, cp[20:18]};
               seq[1] = {2'b10, cp[17:12]};
               seq[2] = {2'b10, cp[11:6]};
               seq[3] = {2'b10, cp[5:0]};
               len    = 4;
            end
         endcase
         // damage the character
         if ($urandom_range(0, 99) < break_pct) begin
            case ($urandom_range(0, 3))
               0: seq[$urandom_range(0, len - 1)] = 8'($urandom);
               1: if (len > 1) len = $urandom_range(1, len - 1);
               2: seq[0] = 8'($urandom_range(0, 1) ? $urandom_range('h80, 'hC1)
                                                   : $urandom_range('hF5, 'hFF));
               default: begin
                  // special leads with any continuation byte
                  if (cls == 2) begin
                     seq[0] = $urandom_range(0, 1) ? LEAD_E0 : LEAD_ED;
                  end else if (cls == 3) begin
                     seq[0] = $urandom_range(0, 1) ? LEAD_F0 : LEAD_F4;
                  end
                  if (len > 1) seq[1] = 8'($urandom_range('h80, 'hBF));
               end
            endcase
         end
         for (int k = 0; k < len; k++) bq.push_back(seq[k]);
      end
      foreach (bq[i]) send_byte(bq[i], i == bq.size() - 1);
   endtask

   // result side: random stalls, check each result transfer
   initial begin
      int unsigned gap;
      rsp_stall <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
         sb.check_result(rsp_code_point, rsp_kind, rsp_last_of_run, rsp_stream_done);
      end
   end

   // main sequence
   initial begin
      int unsigned target;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_input_byte <= 8'd0;
      req_last_byte  <= 1'b0;
      psel           <= 1'b0;
      penable        <= 1'b0;
      pwrite         <= 1'b0;
      paddr          <= '0;
      pwdata         <= 32'd0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // strict mode after reset: field extremes and range limits
      send_byte(8'h00, 1'b0);
      send_byte(8'h7F, 1'b0);
      send_byte(8'hC2, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hED, 1'b0);
      send_byte(8'h9F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h8F, 1'b0);
      send_byte(8'hBF, 1'b0);
      send_byte(8'hBF, 1'b1);
      // illegal lead halts until the end mark
      send_byte(8'hC0, 1'b0);
      send_byte(8'h41, 1'b0);
      send_byte(8'h42, 1'b1);
      // sequence cut by the end mark
      send_byte(8'hE0, 1'b1);
      quiesce();

      // lenient mode: replacements and breaking bytes taken again
      csr_write(REG_STRICT, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hE0, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'hF4, 1'b0);
      send_byte(8'h90, 1'b0);
      send_byte(8'hED, 1'b0);
      send_byte(8'hA0, 1'b0);
      send_byte(8'hC2, 1'b0);
      send_byte(8'h41, 1'b1);
      send_byte(8'hC2, 1'b1);
      quiesce();

      // random streams under each register setting
      for (int ph = 0; ph < 4; ph++) begin
         csr_write(REG_STRICT, ph[1]);
         csr_write(REG_PARTIAL, ph[0]);
         target = bytes_decoded + PHASE_BYTES;
         while (bytes_decoded < target) begin
            if ($urandom_range(0, 9) == 0) begin
               play_stream($urandom_range(1, 6), 100);
            end else begin
               play_stream($urandom_range(1, 12), 12);
            end
         end
         quiesce();
      end

      repeat (10) @(posedge clock);
      if (sb.expected_q.size() != 0) begin
         $error("%0d expected results never arrived", sb.expected_q.size());
         sb.fails++;
      end
      if (sb.fails == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
